/* src/rcnh_pkg.sv */
`timescale 1ns / 1ps
package rcnh_pkg;

  localparam int FRAC_BITS    = 8;
  localparam int CORDIC_STEPS = 16;
  localparam int COORD_BITS   = 14;

  localparam int CORDIC_Q    = 30;
  localparam int CORDIC_GAIN = 652032874;
  localparam int ANG_FRAC    = 16;

  // field widths of the ports
  localparam int IN_POS_W   = 14;
  localparam int IN_ANG_W   = 12;
  localparam int OFS_W      = 11;
  localparam int OFS_ANG_W  = 10;
  localparam int RAD_CFG_W  = 10;
  localparam int DIST_W     = 14;
  localparam int OUT_POS_W  = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  // internal widths
  localparam int ANG_W   = 13;
  localparam int TRIG_W  = CORDIC_STEPS + 2;
  localparam int CX_W    = CORDIC_Q + 4;
  localparam int CZ_W    = 25;
  localparam int CI_W    = $clog2(CORDIC_STEPS);
  localparam int RAD_W   = RAD_CFG_W + FRAC_BITS;
  localparam int SQ_W    = 2 * RAD_W;
  localparam int POS_W   = IN_POS_W + FRAC_BITS + 2;
  localparam int VEC_W   = POS_W + 1;
  localparam int MUL_A_W = POS_W + 5;
  localparam int MUL_B_W = ((TRIG_W > RAD_W) ? TRIG_W : RAD_W) + 1;
  localparam int ACC_W   = MUL_A_W + MUL_B_W + 1;
  localparam int TN_W    = MUL_A_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_ANGLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE = 3'd4;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_REDUCE,
    CS_QUAD,
    CS_ITER,
    CS_OUT
  } cordic_st_e;

  typedef enum logic {
    SQ_IDLE,
    SQ_RUN
  } sqrt_st_e;

  typedef enum logic [1:0] {
    MAC_HOLD,
    MAC_LOAD,
    MAC_ADD,
    MAC_SUB
  } mac_op_e;

  typedef struct packed {
    mac_op_e                     op;
    logic signed [MUL_A_W-1:0]   a;
    logic signed [MUL_B_W-1:0]   b;
  } mac_req_t;

  typedef enum logic [4:0] {
    T_IDLE,
    T_TRIG_R,
    T_TRIG_RW,
    T_TRIG_S,
    T_TRIG_SW,
    T_PX0,
    T_PX1,
    T_PY0,
    T_PY1,
    T_PEND,
    T_VEC,
    T_T0,
    T_T1,
    T_C0,
    T_C1,
    T_R0,
    T_R1,
    T_SQ,
    T_SQW,
    T_TN,
    T_H0,
    T_H1,
    T_H2,
    T_FIN
  } top_st_e;

  // atan(2^-i) in degrees, Q16
  function automatic logic [CZ_W-1:0] atan_deg(input logic [4:0] idx);
    logic [CZ_W-1:0] v;
    case (idx)
      5'd0:  v = 25'd2949120;
      5'd1:  v = 25'd1740967;
      5'd2:  v = 25'd919879;
      5'd3:  v = 25'd466945;
      5'd4:  v = 25'd234379;
      5'd5:  v = 25'd117304;
      5'd6:  v = 25'd58666;
      5'd7:  v = 25'd29335;
      5'd8:  v = 25'd14668;
      5'd9:  v = 25'd7334;
      5'd10: v = 25'd3667;
      5'd11: v = 25'd1833;
      5'd12: v = 25'd917;
      5'd13: v = 25'd458;
      5'd14: v = 25'd229;
      5'd15: v = 25'd115;
      5'd16: v = 25'd57;
      5'd17: v = 25'd29;
      5'd18: v = 25'd14;
      5'd19: v = 25'd7;
      5'd20: v = 25'd4;
      5'd21: v = 25'd2;
      5'd22: v = 25'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* src/ray_circle_nearest_hit_core.sv */
`timescale 1ns / 1ps
// an item that carries no obstacle goes straight to the end, a miss stops after the radius test
// and a hit also waits on the root unit; the first item of a scan first makes
// two runs of the shared cordic unit (angle reduction, then 16 rotations each)
// throughput: one item at a time, in_ready_o is low from a transfer until the item is done
// the result sits in an output register, so the next item can enter while it waits
// reset: asynchronous, active low; config and scan state go to their reset values at once
module ray_circle_nearest_hit_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [rcnh_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [rcnh_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [rcnh_pkg::IN_POS_W-1:0]   robot_x_i,
  input  logic signed [rcnh_pkg::IN_POS_W-1:0]   robot_y_i,
  input  logic signed [rcnh_pkg::IN_ANG_W-1:0]   robot_angle_i,
  input  logic signed [rcnh_pkg::IN_POS_W-1:0]   obstacle_x_i,
  input  logic signed [rcnh_pkg::IN_POS_W-1:0]   obstacle_y_i,
  input  logic                                   obstacle_valid_i,
  input  logic                                   last_obstacle_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [rcnh_pkg::DIST_W-1:0]            distance_o,
  output logic                                   hit_o,
  output logic signed [rcnh_pkg::OUT_POS_W-1:0]  hit_x_o,
  output logic signed [rcnh_pkg::OUT_POS_W-1:0]  hit_y_o
);
  import rcnh_pkg::*;

  localparam int PoseSh = CORDIC_STEPS - FRAC_BITS;
  localparam int DotSh  = CORDIC_STEPS;
  localparam logic signed [ACC_W-1:0] PoseRnd = ACC_W'(1) <<< (PoseSh - 1);
  localparam logic signed [ACC_W-1:0] DotRnd  = ACC_W'(1) <<< (DotSh - 1);
  localparam logic signed [ACC_W-1:0] CoordHi = ACC_W'((1 <<< (COORD_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] CoordLo = -CoordHi - ACC_W'(1);

  function automatic logic signed [COORD_BITS-1:0] trunc_sat(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [ACC_W-1:0] t;
    if (v >= 0) t = v >>> FRAC_BITS;
    else t = -((-v) >>> FRAC_BITS);
    if (t > CoordHi) t = CoordHi;
    else if (t < CoordLo) t = CoordLo;
    return t[COORD_BITS-1:0];
  endfunction

  top_st_e state_q, state_d;

  // config
  logic signed [OFS_W-1:0]     ox_q, oy_q;
  logic signed [OFS_ANG_W-1:0] oa_q;
  logic [RAD_CFG_W-1:0]        rad_cfg_q;
  logic [DIST_W-1:0]           maxd_q;

  // item
  logic signed [IN_POS_W-1:0] rx_q, rx_d, ry_q, ry_d, px_q, px_d, py_q, py_d;
  logic signed [IN_ANG_W-1:0] ra_q, ra_d;
  logic                       ov_q, ov_d, last_q, last_d;

  // pose and work registers
  logic                       scan_open_q, scan_open_d;
  logic signed [TRIG_W-1:0]   cr_q, cr_d, sr_q, sr_d, c_q, c_d, s_q, s_d;
  logic signed [POS_W-1:0]    sx_q, sx_d, sy_q, sy_d, pose_new;
  logic signed [VEC_W-1:0]    vx_q, vx_d, vy_q, vy_d;
  logic signed [MUL_A_W-1:0]  tc_q, tc_d, crs_q, crs_d, rad_a;
  logic signed [TN_W-1:0]     tn_q, tn_d, h_s;
  logic signed [COORD_BITS-1:0] hx_q, hx_d;

  // running best
  logic [DIST_W-1:0]            best_dist_q, best_dist_d;
  logic signed [COORD_BITS-1:0] best_x_q, best_x_d, best_y_q, best_y_d;
  logic                         best_valid_q, best_valid_d;

  // output register
  logic                         out_valid_q, out_valid_d, out_hit_q, out_hit_d;
  logic [DIST_W-1:0]            out_dist_q, out_dist_d;
  logic signed [OUT_POS_W-1:0]  out_x_q, out_x_d, out_y_q, out_y_d;

  // shared units
  logic                      cordic_start, cordic_done, sq_start, sq_done;
  logic signed [ANG_W-1:0]   cordic_angle;
  logic signed [TRIG_W-1:0]  cordic_cos, cordic_sin;
  logic [RAD_W-1:0]          sq_root;
  mac_req_t                  mac_req;
  logic signed [ACC_W-1:0]   acc, acc_pose, acc_dot, hfull_x, hfull_y;
  logic                      miss, far, out_free;

  rcnh_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .angle_i (cordic_angle),
    .done_o  (cordic_done),
    .cos_o   (cordic_cos),
    .sin_o   (cordic_sin)
  );

  rcnh_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .value_i (acc[SQ_W-1:0]),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  rcnh_mac u_mac (
    .clk_i (clk_i),
    .req_i (mac_req),
    .acc_o (acc)
  );

  assign acc_pose = (acc + PoseRnd) >>> PoseSh;
  assign acc_dot  = (acc + DotRnd) >>> DotSh;
  assign hfull_x  = ACC_W'(sx_q) + acc_dot;
  assign hfull_y  = ACC_W'(sy_q) + acc_dot;
  assign rad_a    = signed'(MUL_A_W'({rad_cfg_q, {FRAC_BITS{1'b0}}}));
  assign miss     = (crs_q > rad_a) || (crs_q < -rad_a);
  assign far      = (tn_q <= 0) ||
                    (tn_q[TN_W-1:FRAC_BITS] >= (TN_W - FRAC_BITS)'(best_dist_q));
  assign h_s      = signed'(TN_W'(sq_root));
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      T_IDLE: begin
        if (in_valid_i) begin
          if (!scan_open_q) state_d = T_TRIG_R;
          else if (obstacle_valid_i) state_d = T_VEC;
          else state_d = T_FIN;
        end
      end
      T_TRIG_R:  state_d = T_TRIG_RW;
      T_TRIG_RW: begin
        if (cordic_done) state_d = T_TRIG_S;
      end
      T_TRIG_S:  state_d = T_TRIG_SW;
      T_TRIG_SW: begin
        if (cordic_done) state_d = T_PX0;
      end
      T_PX0: state_d = T_PX1;
      T_PX1: state_d = T_PY0;
      T_PY0: state_d = T_PY1;
      T_PY1: state_d = T_PEND;
      T_PEND: state_d = ov_q ? T_VEC : T_FIN;
      T_VEC: state_d = T_T0;
      T_T0:  state_d = T_T1;
      T_T1:  state_d = T_C0;
      T_C0:  state_d = T_C1;
      T_C1:  state_d = T_R0;
      T_R0:  state_d = T_R1;
      T_R1:  state_d = miss ? T_FIN : T_SQ;
      T_SQ:  state_d = T_SQW;
      T_SQW: begin
        if (sq_done) state_d = T_TN;
      end
      T_TN:  state_d = far ? T_FIN : T_H0;
      T_H0:  state_d = T_H1;
      T_H1:  state_d = T_H2;
      T_H2:  state_d = T_FIN;
      T_FIN: begin
        if (!last_q || out_free) state_d = T_IDLE;
      end
      default: state_d = T_IDLE;
    endcase
  end

  always_comb begin
    rx_d = rx_q;
    ry_d = ry_q;
    ra_d = ra_q;
    px_d = px_q;
    py_d = py_q;
    ov_d = ov_q;
    last_d = last_q;
    scan_open_d = scan_open_q;
    cr_d = cr_q;
    sr_d = sr_q;
    c_d  = c_q;
    s_d  = s_q;
    sx_d = sx_q;
    sy_d = sy_q;
    vx_d = vx_q;
    vy_d = vy_q;
    tc_d = tc_q;
    crs_d = crs_q;
    tn_d = tn_q;
    hx_d = hx_q;
    best_dist_d  = best_dist_q;
    best_x_d     = best_x_q;
    best_y_d     = best_y_q;
    best_valid_d = best_valid_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_dist_d   = out_dist_q;
    out_hit_d    = out_hit_q;
    out_x_d      = out_x_q;
    out_y_d      = out_y_q;
    cordic_start = 1'b0;
    cordic_angle = ANG_W'(ra_q);
    sq_start     = 1'b0;
    mac_req.op   = MAC_HOLD;
    mac_req.a    = '0;
    mac_req.b    = '0;
    in_ready_o   = (state_q == T_IDLE);
    pose_new = (POS_W'(state_q == T_PEND ? ry_q : rx_q) <<< FRAC_BITS)
             + acc_pose[POS_W-1:0];
    case (state_q)
      T_IDLE: begin
        if (in_valid_i) begin
          rx_d   = robot_x_i;
          ry_d   = robot_y_i;
          ra_d   = robot_angle_i;
          px_d   = obstacle_x_i;
          py_d   = obstacle_y_i;
          ov_d   = obstacle_valid_i;
          last_d = last_obstacle_i;
        end
      end
      T_TRIG_R: begin
        cordic_start = 1'b1;
      end
      T_TRIG_RW: begin
        if (cordic_done) begin
          cr_d = cordic_cos;
          sr_d = cordic_sin;
        end
      end
      T_TRIG_S: begin
        cordic_start = 1'b1;
        cordic_angle = ANG_W'(ra_q) + ANG_W'(oa_q);
      end
      T_TRIG_SW: begin
        if (cordic_done) begin
          c_d = cordic_cos;
          s_d = cordic_sin;
        end
      end
      T_PX0: begin
        mac_req.op = MAC_LOAD;
        mac_req.a  = MUL_A_W'(ox_q);
        mac_req.b  = MUL_B_W'(cr_q);
      end
      T_PX1: begin
        mac_req.op = MAC_ADD;
        mac_req.a  = MUL_A_W'(oy_q);
        mac_req.b  = MUL_B_W'(sr_q);
      end
      T_PY0: begin
        sx_d       = pose_new;
        mac_req.op = MAC_LOAD;
        mac_req.a  = MUL_A_W'(ox_q);
        mac_req.b  = MUL_B_W'(sr_q);
      end
      T_PY1: begin
        mac_req.op = MAC_SUB;
        mac_req.a  = MUL_A_W'(oy_q);
        mac_req.b  = MUL_B_W'(cr_q);
      end
      T_PEND: begin
        sy_d         = pose_new;
        best_dist_d  = maxd_q;
        best_x_d     = '0;
        best_y_d     = '0;
        best_valid_d = 1'b0;
        scan_open_d  = 1'b1;
      end
      T_VEC: begin
        vx_d = (VEC_W'(px_q) <<< FRAC_BITS) - VEC_W'(sx_q);
        vy_d = (VEC_W'(py_q) <<< FRAC_BITS) - VEC_W'(sy_q);
      end
      T_T0: begin
        mac_req.op = MAC_LOAD;
        mac_req.a  = MUL_A_W'(vx_q);
        mac_req.b  = MUL_B_W'(c_q);
      end
      T_T1: begin
        mac_req.op = MAC_ADD;
        mac_req.a  = MUL_A_W'(vy_q);
        mac_req.b  = MUL_B_W'(s_q);
      end
      T_C0: begin
        tc_d       = acc_dot[MUL_A_W-1:0];
        mac_req.op = MAC_LOAD;
        mac_req.a  = MUL_A_W'(vx_q);
        mac_req.b  = MUL_B_W'(s_q);
      end
      T_C1: begin
        mac_req.op = MAC_SUB;
        mac_req.a  = MUL_A_W'(vy_q);
        mac_req.b  = MUL_B_W'(c_q);
      end
      T_R0: begin
        crs_d      = acc_dot[MUL_A_W-1:0];
        mac_req.op = MAC_LOAD;
        mac_req.a  = rad_a;
        mac_req.b  = rad_a[MUL_B_W-1:0];
      end
      T_R1: begin
        if (!miss) begin
          mac_req.op = MAC_SUB;
          mac_req.a  = crs_q;
          mac_req.b  = signed'(crs_q[MUL_B_W-1:0]);
        end
      end
      T_SQ: begin
        sq_start = 1'b1;
      end
      T_SQW: begin
        if (sq_done) begin
          if (tc_q >= 0) tn_d = TN_W'(tc_q) - h_s;
          else tn_d = TN_W'(tc_q) + h_s;
        end
      end
      T_H0: begin
        mac_req.op = MAC_LOAD;
        mac_req.a  = tn_q[MUL_A_W-1:0];
        mac_req.b  = MUL_B_W'(c_q);
      end
      T_H1: begin
        hx_d       = trunc_sat(hfull_x);
        mac_req.op = MAC_LOAD;
        mac_req.a  = tn_q[MUL_A_W-1:0];
        mac_req.b  = MUL_B_W'(s_q);
      end
      T_H2: begin
        best_dist_d  = tn_q[FRAC_BITS +: DIST_W];
        best_x_d     = hx_q;
        best_y_d     = trunc_sat(hfull_y);
        best_valid_d = 1'b1;
      end
      T_FIN: begin
        if (last_q && out_free) begin
          out_valid_d = 1'b1;
          out_dist_d  = best_dist_q;
          out_hit_d   = best_valid_q;
          out_x_d     = best_valid_q ? OUT_POS_W'(best_x_q) : '0;
          out_y_d     = best_valid_q ? OUT_POS_W'(best_y_q) : '0;
          scan_open_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox_q      <= '0;
      oy_q      <= '0;
      oa_q      <= '0;
      rad_cfg_q <= RAD_CFG_W'(35);
      maxd_q    <= DIST_W'(4000);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_OFFSET_X:     ox_q      <= cfg_data_i[OFS_W-1:0];
        REG_OFFSET_Y:     oy_q      <= cfg_data_i[OFS_W-1:0];
        REG_OFFSET_ANGLE: oa_q      <= cfg_data_i[OFS_ANG_W-1:0];
        REG_RADIUS:       rad_cfg_q <= cfg_data_i[RAD_CFG_W-1:0];
        REG_MAX_DISTANCE: maxd_q    <= cfg_data_i[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= T_IDLE;
      scan_open_q  <= 1'b0;
      best_valid_q <= 1'b0;
      best_dist_q  <= DIST_W'(4000);
      best_x_q     <= '0;
      best_y_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      scan_open_q  <= scan_open_d;
      best_valid_q <= best_valid_d;
      best_dist_q  <= best_dist_d;
      best_x_q     <= best_x_d;
      best_y_q     <= best_y_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rx_q   <= rx_d;
    ry_q   <= ry_d;
    ra_q   <= ra_d;
    px_q   <= px_d;
    py_q   <= py_d;
    ov_q   <= ov_d;
    last_q <= last_d;
    cr_q   <= cr_d;
    sr_q   <= sr_d;
    c_q    <= c_d;
    s_q    <= s_d;
    sx_q   <= sx_d;
    sy_q   <= sy_d;
    vx_q   <= vx_d;
    vy_q   <= vy_d;
    tc_q   <= tc_d;
    crs_q  <= crs_d;
    tn_q   <= tn_d;
    hx_q   <= hx_d;
    out_dist_q <= out_dist_d;
    out_hit_q  <= out_hit_d;
    out_x_q    <= out_x_d;
    out_y_q    <= out_y_d;
  end

  assign out_valid_o = out_valid_q;
  assign distance_o  = out_dist_q;
  assign hit_o       = out_hit_q;
  assign hit_x_o     = out_x_q;
  assign hit_y_o     = out_y_q;

endmodule

/* src/rcnh_cordic.sv */
`timescale 1ns / 1ps
module rcnh_cordic (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [rcnh_pkg::ANG_W-1:0]  angle_i,
  output logic                               done_o,
  output logic signed [rcnh_pkg::TRIG_W-1:0] cos_o,
  output logic signed [rcnh_pkg::TRIG_W-1:0] sin_o
);
  import rcnh_pkg::*;

  localparam int RndSh = CORDIC_Q - CORDIC_STEPS;
  localparam logic signed [ANG_W-1:0] Full    = ANG_W'(360);
  localparam logic signed [ANG_W-1:0] Quarter = ANG_W'(90);
  localparam logic signed [CX_W-1:0]  RndOne  = CX_W'(1) <<< (RndSh - 1);

  cordic_st_e state_q, state_d;
  logic signed [ANG_W-1:0]  ang_q, ang_d;
  logic [1:0]               quad_q, quad_d;
  logic signed [CX_W-1:0]   x_q, x_d, y_q, y_d, dx, dy, cr, sr;
  logic signed [CZ_W-1:0]   z_q, z_d, step;
  logic [CI_W-1:0]          i_q, i_d;
  logic signed [TRIG_W-1:0] cos_q, cos_d, sin_q, sin_d, cr_t, sr_t;
  logic                     done_q, done_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_IDLE: begin
        if (start_i) state_d = CS_REDUCE;
      end
      CS_REDUCE: begin
        if (ang_q >= 0 && ang_q < Full) state_d = CS_QUAD;
      end
      CS_QUAD: begin
        if (ang_q < Quarter) state_d = CS_ITER;
      end
      CS_ITER: begin
        if (i_q == CI_W'(CORDIC_STEPS - 1)) state_d = CS_OUT;
      end
      CS_OUT:  state_d = CS_IDLE;
      default: state_d = CS_IDLE;
    endcase
  end

  always_comb begin
    ang_d  = ang_q;
    quad_d = quad_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    i_d    = i_q;
    cos_d  = cos_q;
    sin_d  = sin_q;
    done_d = 1'b0;
    dx     = y_q >>> i_q;
    dy     = x_q >>> i_q;
    step   = signed'(atan_deg(5'(i_q)));
    cr     = (x_q + RndOne) >>> RndSh;
    sr     = (y_q + RndOne) >>> RndSh;
    cr_t   = cr[TRIG_W-1:0];
    sr_t   = sr[TRIG_W-1:0];
    case (state_q)
      CS_IDLE: begin
        if (start_i) begin
          ang_d  = angle_i;
          quad_d = '0;
        end
      end
      CS_REDUCE: begin
        if (ang_q < 0) ang_d = ang_q + Full;
        else if (ang_q >= Full) ang_d = ang_q - Full;
      end
      CS_QUAD: begin
        if (ang_q >= Quarter) begin
          ang_d  = ang_q - Quarter;
          quad_d = quad_q + 2'd1;
        end else begin
          z_d = CZ_W'(ang_q) <<< ANG_FRAC;
          x_d = CX_W'(CORDIC_GAIN);
          y_d = '0;
          i_d = '0;
        end
      end
      CS_ITER: begin
        if (z_q >= 0) begin
          x_d = x_q - dx;
          y_d = y_q + dy;
          z_d = z_q - step;
        end else begin
          x_d = x_q + dx;
          y_d = y_q - dy;
          z_d = z_q + step;
        end
        i_d = i_q + 1'b1;
      end
      CS_OUT: begin
        done_d = 1'b1;
        case (quad_q)
          2'd0: begin
            cos_d = cr_t;
            sin_d = sr_t;
          end
          2'd1: begin
            cos_d = -sr_t;
            sin_d = cr_t;
          end
          2'd2: begin
            cos_d = -cr_t;
            sin_d = -sr_t;
          end
          default: begin
            cos_d = sr_t;
            sin_d = -cr_t;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ang_q  <= ang_d;
    quad_q <= quad_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    i_q    <= i_d;
    cos_q  <= cos_d;
    sin_q  <= sin_d;
  end

  assign done_o = done_q;
  assign cos_o  = cos_q;
  assign sin_o  = sin_q;

endmodule

/* src/rcnh_isqrt.sv */
`timescale 1ns / 1ps
module rcnh_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rcnh_pkg::SQ_W-1:0]  value_i,
  output logic                       done_o,
  output logic [rcnh_pkg::RAD_W-1:0] root_o
);
  import rcnh_pkg::*;

  localparam int RemW = RAD_W + 3;
  localparam int CntW = $clog2(RAD_W);

  sqrt_st_e state_q, state_d;
  logic [SQ_W-1:0]  val_q, val_d;
  logic [RemW-1:0]  rem_q, rem_d, rem_t, trial;
  logic [RAD_W-1:0] root_q, root_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             done_q, done_d, last;

  assign last = (cnt_q == CntW'(RAD_W - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      SQ_IDLE: begin
        if (start_i) state_d = SQ_RUN;
      end
      SQ_RUN: begin
        if (last) state_d = SQ_IDLE;
      end
      default: state_d = SQ_IDLE;
    endcase
  end

  // two radicand bits per step, one root bit out
  always_comb begin
    val_d  = val_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_t  = {rem_q[RemW-3:0], val_q[SQ_W-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    case (state_q)
      SQ_IDLE: begin
        if (start_i) begin
          val_d  = value_i;
          rem_d  = '0;
          root_d = '0;
          cnt_d  = '0;
        end
      end
      SQ_RUN: begin
        val_d = val_q << 2;
        cnt_d = cnt_q + 1'b1;
        if (rem_t >= trial) begin
          rem_d  = rem_t - trial;
          root_d = {root_q[RAD_W-2:0], 1'b1};
        end else begin
          rem_d  = rem_t;
          root_d = {root_q[RAD_W-2:0], 1'b0};
        end
        done_d = last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    cnt_q  <= cnt_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

/* src/rcnh_mac.sv */
`timescale 1ns / 1ps
module rcnh_mac (
  input  logic                              clk_i,
  input  rcnh_pkg::mac_req_t                req_i,
  output logic signed [rcnh_pkg::ACC_W-1:0] acc_o
);
  import rcnh_pkg::*;

  logic signed [MUL_A_W+MUL_B_W-1:0] prod;
  logic signed [ACC_W-1:0]           prod_x, acc_q, acc_d;

  assign prod   = req_i.a * req_i.b;
  assign prod_x = ACC_W'(prod);

  always_comb begin
    case (req_i.op)
      MAC_LOAD: acc_d = prod_x;
      MAC_ADD:  acc_d = acc_q + prod_x;
      MAC_SUB:  acc_d = acc_q - prod_x;
      default:  acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

/* src/rcnh_checker.sv */
`timescale 1ns / 1ps
module rcnh_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_valid_i,
  input logic                                   in_ready_o,
  input logic                                   out_valid_o,
  input logic                                   out_ready_i,
  input logic [rcnh_pkg::DIST_W-1:0]            distance_o,
  input logic                                   hit_o,
  input logic signed [rcnh_pkg::OUT_POS_W-1:0]  hit_x_o,
  input logic signed [rcnh_pkg::OUT_POS_W-1:0]  hit_y_o
);

  // one item in flight: no transfer in the cycle after a transfer
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(distance_o) && $stable(hit_o)
      && $stable(hit_x_o) && $stable(hit_y_o))
    else $error("stalled result changed");

  a_no_hit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> hit_x_o == 0 && hit_y_o == 0)
    else $error("hit point set without a hit");

  // a result only comes out of work on an item, never straight from idle
  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared while idle");

endmodule

bind ray_circle_nearest_hit_core rcnh_checker u_rcnh_checker (.*);

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
module tb;
  import rcnh_pkg::*;

  localparam int          WATCHDOG_LIMIT = 20000;
  localparam int          SETTLE_CYCLES  = 200;
  localparam logic [2:0]  REG_UNUSED_LO  = 3'd5;
  localparam logic [2:0]  REG_UNUSED_HI  = 3'd7;

  typedef struct {
    logic signed [IN_POS_W-1:0] rx;
    logic signed [IN_POS_W-1:0] ry;
    logic signed [IN_ANG_W-1:0] ang;
    logic signed [IN_POS_W-1:0] ox;
    logic signed [IN_POS_W-1:0] oy;
    logic                       ov;
    logic                       last;
  } scan_item_t;

  typedef struct {
    logic [DIST_W-1:0]           distance;
    logic                        hit;
    logic signed [OUT_POS_W-1:0] hit_x;
    logic signed [OUT_POS_W-1:0] hit_y;
  } range_result_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]              cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]             cfg_data_i = '0;
  logic                              in_valid_i = 1'b0;
  logic                              in_ready_o;
  logic signed [IN_POS_W-1:0]        robot_x_i = '0;
  logic signed [IN_POS_W-1:0]        robot_y_i = '0;
  logic signed [IN_ANG_W-1:0]        robot_angle_i = '0;
  logic signed [IN_POS_W-1:0]        obstacle_x_i = '0;
  logic signed [IN_POS_W-1:0]        obstacle_y_i = '0;
  logic                              obstacle_valid_i = 1'b0;
  logic                              last_obstacle_i = 1'b0;
  logic                              out_valid_o;
  logic                              out_ready_i = 1'b0;
  logic [DIST_W-1:0]                 distance_o;
  logic                              hit_o;
  logic signed [OUT_POS_W-1:0]       hit_x_o;
  logic signed [OUT_POS_W-1:0]       hit_y_o;

  ray_circle_nearest_hit_core dut (.*);

  always #2 clk_i = ~clk_i;

  // predictor state
  longint        ofs_x, ofs_y, ofs_ang, radius, max_dist;
  bit            scan_open, best_hit;
  longint        best_dist, best_x, best_y;
  longint        pose_x, pose_y, pose_c, pose_s;
  range_result_t range_q[$];

  int send_idle_pct, recv_stall_pct;
  int errors, items_sent, results_seen, hits_seen, cfg_writes;
  int idle_cycles = 0;

  function automatic longint sext(longint v, int w);
    longint m;
    m = (longint'(1) << w) - 1;
    v = v & m;
    if (v[w-1]) v = v - (longint'(1) << w);
    return v;
  endfunction

  function automatic longint round_down(longint v, int from_q, int to_q);
    int n;
    n = from_q - to_q;
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint trunc_frac(longint v);
    if (v >= 0) return v >>> FRAC_BITS;
    return -((-v) >>> FRAC_BITS);
  endfunction

  function automatic longint sat_coord(longint v);
    longint hi, lo;
    hi = (longint'(1) << (COORD_BITS - 1)) - 1;
    lo = -(longint'(1) << (COORD_BITS - 1));
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  // cos and sin of whole degrees in Q(CORDIC_STEPS)
  task automatic sin_cos_deg(input longint deg, output longint co, output longint si);
    longint a, q, x, y, z, dx, dy, c, s;
    a = ((deg % 360) + 360) % 360;
    q = a / 90;
    x = CORDIC_GAIN;
    y = 0;
    z = (a % 90) * 65536;
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(atan_deg(i[4:0]));
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(atan_deg(i[4:0]));
      end
    end
    c = round_down(x, CORDIC_Q, CORDIC_STEPS);
    s = round_down(y, CORDIC_Q, CORDIC_STEPS);
    case (q)
      0: begin co = c;  si = s;  end
      1: begin co = -s; si = c;  end
      2: begin co = -c; si = -s; end
      default: begin co = s; si = -c; end
    endcase
  endtask

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input longint v);
    case (idx)
      REG_OFFSET_X:     ofs_x = sext(v, OFS_W);
      REG_OFFSET_Y:     ofs_y = sext(v, OFS_W);
      REG_OFFSET_ANGLE: ofs_ang = sext(v, OFS_ANG_W);
      REG_RADIUS:       radius = v & 10'h3ff;
      REG_MAX_DISTANCE: max_dist = v & 14'h3fff;
      default: ;
    endcase
  endtask

  task automatic latch_pose(input scan_item_t it);
    longint cr, sr;
    sin_cos_deg(it.ang, cr, sr);
    sin_cos_deg(longint'(it.ang) + ofs_ang, pose_c, pose_s);
    pose_x = (longint'(it.rx) <<< FRAC_BITS)
           + round_down(ofs_x * cr + ofs_y * sr, CORDIC_STEPS, FRAC_BITS);
    pose_y = (longint'(it.ry) <<< FRAC_BITS)
           + round_down(ofs_x * sr - ofs_y * cr, CORDIC_STEPS, FRAC_BITS);
    best_dist = max_dist;
    best_x = 0;
    best_y = 0;
    best_hit = 0;
    scan_open = 1;
  endtask

  task automatic cast_ray(input longint px, input longint py);
    longint vx, vy, tc, cr, rad, h, tn, tn_mm;
    vx = (px <<< FRAC_BITS) - pose_x;
    vy = (py <<< FRAC_BITS) - pose_y;
    tc = round_down(vx * pose_c + vy * pose_s, FRAC_BITS + CORDIC_STEPS, FRAC_BITS);
    cr = round_down(vx * pose_s - vy * pose_c, FRAC_BITS + CORDIC_STEPS, FRAC_BITS);
    rad = radius <<< FRAC_BITS;
    if (cr > rad || cr < -rad) return;
    h = root_floor(rad * rad - cr * cr);
    tn = tc >= 0 ? tc - h : tc + h;
    if (tn <= 0) return;
    tn_mm = tn >>> FRAC_BITS;
    if (tn_mm >= best_dist) return;
    best_dist = tn_mm;
    best_x = sat_coord(trunc_frac(pose_x + round_down(tn * pose_c, FRAC_BITS + CORDIC_STEPS,
                                                      FRAC_BITS)));
    best_y = sat_coord(trunc_frac(pose_y + round_down(tn * pose_s, FRAC_BITS + CORDIC_STEPS,
                                                      FRAC_BITS)));
    best_hit = 1;
  endtask

  task automatic predict_range(input scan_item_t it);
    range_result_t r;
    if (!scan_open) latch_pose(it);
    if (it.ov) cast_ray(it.ox, it.oy);
    if (it.last) begin
      r.distance = best_dist[DIST_W-1:0];
      r.hit = best_hit;
      r.hit_x = best_hit ? best_x[OUT_POS_W-1:0] : '0;
      r.hit_y = best_hit ? best_y[OUT_POS_W-1:0] : '0;
      range_q.push_back(r);
      scan_open = 0;
    end
  endtask

  // called at a rising edge; returns at the edge of the transfer or after the gap
  task automatic send_item(input scan_item_t it);
    int gap;
    in_valid_i       <= 1'b1;
    robot_x_i        <= it.rx;
    robot_y_i        <= it.ry;
    robot_angle_i    <= it.ang;
    obstacle_x_i     <= it.ox;
    obstacle_y_i     <= it.oy;
    obstacle_valid_i <= it.ov;
    last_obstacle_i  <= it.last;
    do @(posedge clk_i); while (!in_ready_o);
    predict_range(it);
    items_sent++;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (range_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint v);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    apply_reg(idx, v[CFG_DATA_W-1:0]);
    cfg_writes++;
    @(posedge clk_i);
  endtask

  task automatic set_config(input longint ox, input longint oy, input longint oa,
                            input longint rad, input longint md);
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Y, oy);
    write_reg(REG_OFFSET_ANGLE, oa);
    write_reg(REG_RADIUS, rad);
    write_reg(REG_MAX_DISTANCE, md);
  endtask

  function automatic scan_item_t make_item(longint rx, longint ry, longint ang, longint ox,
                                           longint oy, bit ov, bit last);
    scan_item_t it;
    it.rx = rx[IN_POS_W-1:0];
    it.ry = ry[IN_POS_W-1:0];
    it.ang = ang[IN_ANG_W-1:0];
    it.ox = ox[IN_POS_W-1:0];
    it.oy = oy[IN_POS_W-1:0];
    it.ov = ov;
    it.last = last;
    return it;
  endfunction

  function automatic longint clamp_pos(longint v);
    return v > 8191 ? 8191 : (v < -8192 ? -8192 : v);
  endfunction

  function automatic longint rand_bits(int w);
    return sext(longint'($urandom), w);
  endfunction

  task automatic send_random_scan();
    longint rx, ry, ang, c, s, d, j, ox, oy;
    int n;
    bit noise;
    noise = $urandom_range(99) < 15;
    n = $urandom_range(1, 6);
    if ($urandom_range(3) == 0) begin
      rx = rand_bits(IN_POS_W); ry = rand_bits(IN_POS_W); ang = rand_bits(IN_ANG_W);
    end else begin
      rx = longint'($urandom_range(8000)) - 4000;
      ry = longint'($urandom_range(8000)) - 4000;
      ang = longint'($urandom_range(2160)) - 1080;
    end
    sin_cos_deg(ang + ofs_ang, c, s);
    for (int i = 0; i < n; i++) begin
      d = longint'($urandom_range(4500)) - 300;
      j = longint'($urandom_range(2 * radius + 40)) - radius - 20;
      ox = clamp_pos(rx + ((d * c - j * s) >>> CORDIC_STEPS));
      oy = clamp_pos(ry + ((d * s + j * c) >>> CORDIC_STEPS));
      if (noise) begin
        ox = rand_bits(IN_POS_W); oy = rand_bits(IN_POS_W);
      end
      send_item(make_item(i == 0 ? rx : rand_bits(IN_POS_W), i == 0 ? ry : rand_bits(IN_POS_W),
                          i == 0 ? ang : rand_bits(IN_ANG_W), ox, oy,
                          $urandom_range(9) != 0, i == n - 1));
    end
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // empty scan
    send_item(make_item(0, 0, 0, 0, 0, 0, 1));
    // straight ahead, behind, missing, abeam
    send_item(make_item(0, 0, 0, 1000, 0, 1, 0));
    send_item(make_item(5, 5, 90, -1000, 0, 1, 0));
    send_item(make_item(0, 0, 0, 500, 100, 1, 0));
    send_item(make_item(0, 0, 0, 0, 20, 1, 1));
    // sensor inside circle
    send_item(make_item(100, 100, 45, 110, 95, 1, 1));
    // angles out of range and quadrants
    send_item(make_item(0, 0, -2048, 0, 0, 0, 0));
    send_item(make_item(0, 0, 0, 300, -300, 1, 1));
    send_item(make_item(0, 0, 2047, -300, 300, 1, 1));
    send_item(make_item(0, 0, 180, -2000, 0, 1, 1));
    send_item(make_item(0, 0, 270, 0, -2000, 1, 1));
    // field extremes
    send_item(make_item(-8192, -8192, 45, 8191, 8191, 1, 1));
    send_item(make_item(8191, 8191, -135, -8192, -8192, 1, 1));
    // beyond max distance
    send_item(make_item(0, 0, 0, 4100, 0, 1, 1));
    wait_drained();
    // hit point beyond the coordinate range, zero radius, zero max distance
    set_config(1023, 0, 180, 1000, 16383);
    send_item(make_item(8191, 0, 0, 8191, 0, 1, 1));
    send_item(make_item(-8192, 8191, 0, -8192, 8191, 1, 1));
    wait_drained();
    set_config(-1024, -1024, -360, 0, 0);
    send_item(make_item(0, 0, 0, 2000, 0, 1, 1));
    send_item(make_item(0, 0, 30, 100, 100, 1, 1));
    wait_drained();
    // writes to unused indexes
    write_reg(REG_UNUSED_LO, 14'h3fff);
    write_reg(REG_UNUSED_HI, 14'h1234);
    set_config(0, 0, 360, 35, 4000);
    send_item(make_item(0, 0, 0, 1000, 0, 1, 1));
    wait_drained();
  endtask

  task automatic test_idle_phases(input int scans_per_phase);
    int send_pct[4] = '{0, 72, 0, 13};
    int recv_pct[4] = '{0, 0, 72, 13};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_pct[p];
      recv_stall_pct = recv_pct[p];
      for (int k = 0; k < scans_per_phase; k++) send_random_scan();
      wait_drained();
    end
  endtask

  task automatic test_config_sweep();
    set_config(rand_bits(CFG_DATA_W), rand_bits(CFG_DATA_W), rand_bits(CFG_DATA_W),
               $urandom_range(16383), $urandom_range(16383));
    test_idle_phases(5);
    set_config(1023, -1024, 359, 1023, 16383);
    test_idle_phases(5);
    set_config(-300, 200, -45, 0, 3000);
    test_idle_phases(4);
    set_config(150, -80, 90, 60, 2500);
  endtask

  always @(posedge clk_i) begin
    range_result_t exp_r;
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (range_q.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        exp_r = range_q.pop_front();
        if (hit_o) hits_seen++;
        if (distance_o !== exp_r.distance) begin
          $error("distance expected %0d actual %0d", exp_r.distance, distance_o);
          errors++;
        end
        if (hit_o !== exp_r.hit) begin
          $error("hit expected %0d actual %0d", exp_r.hit, hit_o);
          errors++;
        end
        if (hit_x_o !== exp_r.hit_x) begin
          $error("hit_x expected %0d actual %0d", exp_r.hit_x, hit_x_o);
          errors++;
        end
        if (hit_y_o !== exp_r.hit_y) begin
          $error("hit_y expected %0d actual %0d", exp_r.hit_y, hit_y_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    hits_seen = 0;
    cfg_writes = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    apply_reg(REG_OFFSET_X, 0);
    apply_reg(REG_OFFSET_Y, 0);
    apply_reg(REG_OFFSET_ANGLE, 0);
    apply_reg(REG_RADIUS, 35);
    apply_reg(REG_MAX_DISTANCE, 4000);
    scan_open = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_sweep();
    test_idle_phases(20);
    wait_drained();
    $display("ran %0d items in scans, %0d range results (%0d with a hit), %0d register writes",
             items_sent, results_seen, hits_seen, cfg_writes);
    $display("across offset, radius and max distance extremes and four handshake idle mixes");
    if (errors == 0 && range_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* ray_circle_nearest_hit_core.f */
src/rcnh_pkg.sv
src/rcnh_cordic.sv
src/rcnh_isqrt.sv
src/rcnh_mac.sv
src/ray_circle_nearest_hit_core.sv
src/rcnh_checker.sv
tb/sv/tb.sv
